FILE: sv/immb_pkg.sv
// Package: shared types and constants for the min/max to byte normalizer.
`timescale 1ns / 1ps

package immb_pkg;

    localparam int SAMPLE_BITS_DEFAULT = 16;
    localparam int QUOT_BITS           = 8;
    localparam int CNT_BITS            = $clog2(QUOT_BITS);

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_SCAN    = 2'd1,
        CMD_CONVERT = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_PREP,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

FILE: sv/immb_div.sv
// Restoring divider, one quotient bit per cycle, for the byte rescale.
`timescale 1ns / 1ps

module immb_div #(
    parameter int SAMPLE_BITS = immb_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       start,
    input  logic [SAMPLE_BITS+immb_pkg::QUOT_BITS:0]   num,
    input  logic [SAMPLE_BITS:0]                       den,
    output immb_pkg::div_status_t                      status,
    output logic [immb_pkg::QUOT_BITS-1:0]             quotient
);
    import immb_pkg::*;

    localparam int NUM_BITS = SAMPLE_BITS + QUOT_BITS + 1;
    localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(QUOT_BITS - 1);

    logic [NUM_BITS-1:0]  rem_reg, rem_next;
    logic [NUM_BITS-1:0]  dsh_reg, dsh_next;
    logic [QUOT_BITS-1:0] q_reg, q_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 fits;

    // divisor starts aligned to the top quotient bit
    assign fits = (rem_reg >= dsh_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            dsh_next  = NUM_BITS'({den, {(QUOT_BITS-1){1'b0}}});
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            q_next   = {q_reg[QUOT_BITS-2:0], fits};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = q_reg;

endmodule

FILE: sv/intensity_min_max_to_byte_core.sv
// Top level: running min/max tracker and byte rescaler for signed samples.
`timescale 1ns / 1ps
//
//  channel   direction  handshake                    payload
//  -------   ---------  ---------------------------  ---------------------------
//  item      in         item_valid / item_stall      command, sample
//  result    out        result_valid / result_stall  normalized_byte
//
//  Clear and scan words are taken without a stall and produce no result.
//  A convert word holds item_stall through ST_LOAD (range and offset), ST_PREP
//  (numerator and divisor), ST_DIV (bit-serial quotient loop in immb_div plus
//  its done flag) and ST_FINISH (hand off). Saturated offsets skip the divider.
//  rst_n is asynchronous; it sets min to the most positive and max to the most
//  negative value. A waiting result does not block clear or scan words; a
//  finished convert waits only for the result slot.

module intensity_min_max_to_byte_core #(
    parameter int SAMPLE_BITS = immb_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  logic [1:0]                       command,
    input  logic signed [SAMPLE_BITS-1:0]    sample,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [immb_pkg::QUOT_BITS-1:0]   normalized_byte
);
    import immb_pkg::*;

    localparam int NUM_BITS = SAMPLE_BITS + QUOT_BITS + 1;
    localparam int W1       = SAMPLE_BITS + 1;

    localparam logic signed [SAMPLE_BITS-1:0] MOST_POS =
        {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG =
        {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [QUOT_BITS-1:0] BYTE_FULL = '1;

    state_t state_reg, state_next;

    logic signed [SAMPLE_BITS-1:0] min_reg, min_next;
    logic signed [SAMPLE_BITS-1:0] max_reg, max_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic [SAMPLE_BITS-1:0]        range_reg, range_next;
    logic [SAMPLE_BITS-1:0]        off_reg, off_next;
    logic [QUOT_BITS-1:0]          byte_reg, byte_next;
    logic [QUOT_BITS-1:0]          out_byte_reg, out_byte_next;
    logic                          out_valid_reg, out_valid_next;

    logic                          accept;
    logic                          slot_free;
    logic signed [W1-1:0]          range_full;
    logic signed [W1-1:0]          off_full;
    logic [SAMPLE_BITS-1:0]        range_clamp;
    logic                          sat_zero;
    logic                          sat_full;
    logic [NUM_BITS-1:0]           off_ext;
    logic [NUM_BITS-1:0]           div_num;
    logic [W1-1:0]                 div_den;
    logic                          div_start;
    div_status_t                   div_status;
    logic [QUOT_BITS-1:0]          div_quot;

    assign accept    = item_valid && !item_stall;
    assign slot_free = !out_valid_reg || !result_stall;

    // range and offset carry one extra bit so the differences never wrap
    assign range_full = {max_reg[SAMPLE_BITS-1], max_reg} - {min_reg[SAMPLE_BITS-1], min_reg};
    assign off_full   = {sample_reg[SAMPLE_BITS-1], sample_reg}
                      - {min_reg[SAMPLE_BITS-1], min_reg};
    assign range_clamp = (range_full < W1'(1)) ? SAMPLE_BITS'(1)
                                               : range_full[SAMPLE_BITS-1:0];
    assign sat_zero = (off_full <= W1'(0));
    assign sat_full = (off_full >= $signed({1'b0, range_clamp}));

    // numerator off*510 + range, 510 = 2*(2^QUOT_BITS - 1); divisor 2*range
    assign off_ext = NUM_BITS'(off_reg);
    assign div_num = (off_ext << (QUOT_BITS + 1)) - (off_ext << 1) + NUM_BITS'(range_reg);
    assign div_den = {range_reg, 1'b0};

    immb_div #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .status   (div_status),
        .quotient (div_quot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && command == CMD_CONVERT)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = (sat_zero || sat_full) ? ST_FINISH : ST_PREP;
            end
            ST_PREP:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath updates
    always_comb
    begin
        item_stall     = 1'b1;
        div_start      = 1'b0;
        min_next       = min_reg;
        max_next       = max_reg;
        sample_next    = sample_reg;
        range_next     = range_reg;
        off_next       = off_reg;
        byte_next      = byte_reg;
        out_byte_next  = out_byte_reg;
        out_valid_next = out_valid_reg && result_stall;
        case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                if (accept)
                begin
                    case (command)
                        CMD_CLEAR:
                        begin
                            min_next = MOST_POS;
                            max_next = MOST_NEG;
                        end
                        CMD_SCAN:
                        begin
                            if (sample < min_reg)
                            begin
                                min_next = sample;
                            end
                            if (sample > max_reg)
                            begin
                                max_next = sample;
                            end
                        end
                        CMD_CONVERT:
                        begin
                            sample_next = sample;
                        end
                        default:
                        begin
                            min_next = min_reg;
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                range_next = range_clamp;
                off_next   = off_full[SAMPLE_BITS-1:0];
                byte_next  = sat_zero ? '0 : BYTE_FULL;
            end
            ST_PREP:
            begin
                div_start = 1'b1;
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    byte_next = div_quot;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    out_byte_next  = byte_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            min_reg       <= MOST_POS;
            max_reg       <= MOST_NEG;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        range_reg    <= range_next;
        off_reg      <= off_next;
        byte_reg     <= byte_next;
        out_byte_reg <= out_byte_next;
    end

    assign result_valid    = out_valid_reg;
    assign normalized_byte = out_byte_reg;

`ifndef SYNTHESIS
    // a convert word always holds off the next word
    a_convert_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command == CMD_CONVERT) |=> item_stall)
        else $error("convert accepted without stalling the next word");

    // after a scan the span is never empty
    a_scan_span: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command == CMD_SCAN) |=> (min_reg <= max_reg))
        else $error("min above max after scan");

    // a new result only comes out of the hand-off state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        (!$past(out_valid_reg) && out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result appeared outside hand-off");

    // divider completion only while the sequencer waits for it
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == ST_DIV))
        else $error("divider done outside divide state");

    // divider is not restarted while busy
    a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_status.busy)
        else $error("divider restarted while busy");
`endif

endmodule

FILE: tb/immb_checker.sv
// Checker: tracks scan statistics, predicts each byte and compares it with the result channel.
`timescale 1ns / 1ps

module immb_checker #(
    parameter int SAMPLE_BITS = immb_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    input  logic                                 item_stall,
    input  logic [1:0]                           command,
    input  logic signed [SAMPLE_BITS-1:0]        sample,
    input  logic                                 result_valid,
    input  logic                                 result_stall,
    input  logic [immb_pkg::QUOT_BITS-1:0]       normalized_byte,
    input  logic                                 drain_done,
    output int                                   pending_results,
    output int                                   failures
);
    import immb_pkg::*;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_TOP    = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_BOTTOM = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] scan_min = SAMPLE_TOP;
    logic signed [SAMPLE_BITS-1:0] scan_max = SAMPLE_BOTTOM;
    logic [QUOT_BITS-1:0]          expected_bytes[$];
    int                            mismatch_count   = 0;
    int                            bytes_seen       = 0;
    bit                            leftover_checked = 1'b0;

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        mismatch_count++;
    endtask

    // (s - min) * 510 + span over 2 * span, saturated at both ends
    function automatic logic [QUOT_BITS-1:0] rescale_to_byte(
        input logic signed [SAMPLE_BITS-1:0] s
    );
        longint s_wide;
        longint lo;
        longint hi;
        longint span;
        longint offset;
        longint quotient;
        s_wide = s;
        lo     = scan_min;
        hi     = scan_max;
        span   = hi - lo;
        offset = s_wide - lo;
        if (span < 1)
            span = 1;
        if (offset <= 0)
            return '0;
        if (offset >= span)
            return '1;
        quotient = (offset * 510 + span) / (2 * span);
        return quotient[QUOT_BITS-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [QUOT_BITS-1:0] want;
        if (!rst_n)
        begin
            scan_min = SAMPLE_TOP;
            scan_max = SAMPLE_BOTTOM;
            expected_bytes.delete();
            pending_results <= 0;
            failures        <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_bytes.size() == 0)
                    report_mismatch($sformatf("unexpected byte %0d", normalized_byte));
                else
                begin
                    want = expected_bytes.pop_front();
                    if (normalized_byte !== want)
                        report_mismatch($sformatf("byte #%0d: got %0d, want %0d",
                                                  bytes_seen, normalized_byte, want));
                end
                bytes_seen++;
            end

            if (item_valid && !item_stall)
            begin
                case (command)
                    CMD_CLEAR:
                    begin
                        scan_min = SAMPLE_TOP;
                        scan_max = SAMPLE_BOTTOM;
                    end
                    CMD_SCAN:
                    begin
                        if (sample < scan_min)
                            scan_min = sample;
                        if (sample > scan_max)
                            scan_max = sample;
                    end
                    CMD_CONVERT:
                        expected_bytes.push_back(rescale_to_byte(sample));
                    default:
                        ;
                endcase
            end

            if (drain_done && !leftover_checked)
            begin
                leftover_checked = 1'b1;
                if (expected_bytes.size() != 0)
                    report_mismatch($sformatf("%0d bytes never arrived",
                                              expected_bytes.size()));
            end

            pending_results <= expected_bytes.size();
            failures        <= mismatch_count;
        end
    end

endmodule

FILE: tb/intensity_min_max_to_byte_core_tb.sv
// Testbench top: drives clear/scan/convert words and random back-pressure, gives the verdict.
`timescale 1ns / 1ps

module intensity_min_max_to_byte_core_tb;
    import immb_pkg::*;

    localparam int SAMPLE_BITS = SAMPLE_BITS_DEFAULT;

    // Command code the block has no use for; it must be swallowed without effect.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Words that count toward the run length (unused-command words do not).
    localparam int WORD_TARGET = 1450;

    // Receiver hold-off long enough that a finished convert parks in the result
    // slot and the next convert backs up into item_stall.
    localparam int LONG_HOLD = 400;

    // Settle time after the last byte, well past one convert.
    localparam int SETTLE_CYCLES = 40;

    // Slowest quiet stretch in a correct run: a long hold plus a long sender
    // gap plus one convert. Several times that is still well clear.
    localparam int WATCHDOG_LIMIT = 3000;

    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          item_valid   = 1'b0;
    logic                          item_stall;
    logic [1:0]                    command      = CMD_CLEAR;
    logic signed [SAMPLE_BITS-1:0] sample       = '0;
    logic                          result_valid;
    logic                          result_stall = 1'b0;
    logic [QUOT_BITS-1:0]          normalized_byte;

    logic drain_done = 1'b0;
    int   pending_results;
    int   failures;

    int words_sent    = 0;
    int no_gap_left   = 0;
    int hold_requests = 0;
    int idle_cycles   = 0;

    intensity_min_max_to_byte_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .command         (command),
        .sample          (sample),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .normalized_byte (normalized_byte)
    );

    immb_checker #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .command         (command),
        .sample          (sample),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .normalized_byte (normalized_byte),
        .drain_done      (drain_done),
        .pending_results (pending_results),
        .failures        (failures)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Watchdog: any cycle with neither channel moving a word counts; a
    // long enough run of them means the block has hung.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] watchdog: no word moved for %0d cycles", $time, idle_cycles);
                $display("intensity_min_max_to_byte_core verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender gaps: mostly back-to-back, some short gaps, a few long ones,
    // plus occasional stretches of pure back-to-back traffic.
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int roll;
        if (no_gap_left > 0)
        begin
            no_gap_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            no_gap_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one word and hold it until accepted. valid stays high into the next
    // word when there is no gap, so it is only lowered inside the gap branch.
    task automatic send_word(input logic [1:0] cmd, input int value);
        int gap;
        item_valid <= 1'b1;
        command    <= cmd;
        sample     <= value[SAMPLE_BITS-1:0];
        do
            @(posedge clk);
        while (item_stall);
        if (cmd != CMD_UNUSED)
            words_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Sender goes quiet until every predicted byte has come back. It waits for
    // pending_results to update first so the count includes the last accepted word.
    task automatic drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    // Occasional stray word inside an otherwise tidy sequence.
    task automatic maybe_noise();
        if ($urandom_range(0, 99) < 5)
            send_word(2'($urandom_range(0, 3)), $urandom);
    endtask

    // Convert samples cluster around the scanned span so both the rounding
    // path and the two saturation edges get hit; some are fully random.
    function automatic int convert_sample(input int base, input int spread);
        if ($urandom_range(0, 99) < 70)
            return base - 2 + int'($urandom_range(0, spread + 4));
        return $urandom;
    endfunction

    // Well-formed pass: usually a clear, a handful of scans over a chosen span,
    // then converts against it. Span width is picked to cover equal min/max, tiny
    // ranges (coarse rounding), medium and near-full ranges.
    task automatic play_two_pass();
        int base;
        int spread;
        int n_scan;
        int n_conv;
        int k;
        base = int'($urandom_range(0, 65535)) - 32768;
        case ($urandom_range(0, 3))
            0:       spread = 0;
            1:       spread = $urandom_range(1, 4);
            2:       spread = $urandom_range(5, 2000);
            default: spread = $urandom_range(2000, 65535);
        endcase
        if ($urandom_range(0, 9) < 8)
            send_word(CMD_CLEAR, $urandom);
        n_scan = $urandom_range(1, 8);
        for (k = 0; k < n_scan; k++)
        begin
            maybe_noise();
            send_word(CMD_SCAN, base + int'($urandom_range(0, spread)));
        end
        n_conv = $urandom_range(1, 10);
        for (k = 0; k < n_conv; k++)
        begin
            maybe_noise();
            send_word(CMD_CONVERT, convert_sample(base, spread));
        end
    endtask

    // Unstructured burst: any command, any sample.
    task automatic play_noise();
        int n;
        int k;
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++)
            send_word(2'($urandom_range(0, 3)), $urandom);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random runs of stall and no-stall. One assignment per
    // step, and no run is empty. A pending hold request turns into
    // one long stall so the block backs up all the way to its input.
    // ------------------------------------------------------------------
    initial
    begin
        int holds_served;
        int run;
        int roll;
        holds_served = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_requests != holds_served)
            begin
                holds_served++;
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 30)
                begin
                    result_stall <= 1'b1;
                    run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 3);
                end
                else
                begin
                    result_stall <= 1'b0;
                    run = (roll > 94) ? $urandom_range(40, 80) : $urandom_range(1, 8);
                end
                repeat (run) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and verdict.
    // ------------------------------------------------------------------
    initial
    begin
        int pass_count;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Straight out of reset min/max hold their inverted extremes, so the
        // range is forced to 1 and every convert lands at zero.
        send_word(CMD_CONVERT, 32767);
        send_word(CMD_CONVERT, -32768);

        // Full-scale span: both ends, the midpoint and its neighbor.
        send_word(CMD_SCAN, -32768);
        send_word(CMD_SCAN, 32767);
        send_word(CMD_CONVERT, -32768);
        send_word(CMD_CONVERT, 32767);
        send_word(CMD_CONVERT, 0);
        send_word(CMD_CONVERT, -1);

        // Convert right after a clear, before any scan.
        send_word(CMD_CLEAR, 0);
        send_word(CMD_CONVERT, 5);

        // One scanned value: min equals max, range forced to 1.
        send_word(CMD_SCAN, 100);
        send_word(CMD_CONVERT, 100);
        send_word(CMD_CONVERT, 101);
        send_word(CMD_CONVERT, 99);

        // Unused command with alternating sample bits; state must not move.
        send_word(CMD_UNUSED, 32'h5555);
        send_word(CMD_UNUSED, 32'hAAAA);

        // Range of 100: exact half-up rounding, and saturation above the span.
        send_word(CMD_SCAN, 200);
        send_word(CMD_CONVERT, 150);
        send_word(CMD_CONVERT, 199);
        send_word(CMD_CONVERT, 300);

        // Span straddling zero.
        send_word(CMD_CLEAR, -1);
        send_word(CMD_SCAN, -5);
        send_word(CMD_SCAN, 5);
        send_word(CMD_CONVERT, 0);
        drain_results();

        pass_count = 0;
        while (words_sent < WORD_TARGET)
        begin
            pass_count++;
            // Long receiver hold while the sender keeps going.
            if (pass_count == 12 || pass_count == 80)
                hold_requests <= hold_requests + 1;
            // Sender pause until the result queue is empty.
            if (pass_count % 30 == 0)
                drain_results();
            if ($urandom_range(0, 9) < 8)
                play_two_pass();
            else
                play_noise();
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        drain_done <= 1'b1;
        repeat (2) @(posedge clk);

        if (failures == 0)
            $display("intensity_min_max_to_byte_core verification clean");
        else
            $display("intensity_min_max_to_byte_core verification failed");
        $finish;
    end

endmodule
